@@ hw/rtl/chained_hash_table_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Chained hash table assertion macros
// Shared assertion forms for the chained hash table blocks.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_UNIT_MACROS_SVH
`define CHAINED_HASH_TABLE_UNIT_MACROS_SVH

// implication checked every clock outside reset
`define CHT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define CHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// Chained hash table package
// Command codes, mixer constants and the request type between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
package cht_pkg;
  typedef enum logic [1:0] {
    CMD_SET = 2'd0,
    CMD_GET = 2'd1,
    CMD_DEL = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  localparam logic [63:0] MIX_ADD   = 64'd4355467;
  localparam logic [31:0] MIX_MUL   = 32'h045d9f3b;
  localparam int          MIX_SHIFT = 16;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    cmd_t        command;
    logic [63:0] key;
    logic [63:0] value;
    logic [63:0] hash;
  } req_t;

  function automatic logic [63:0] xsh(input logic [63:0] x);
    xsh = x ^ (x >> MIX_SHIFT);
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/chained_hash_table_unit.sv @@
// ----------------------------------------------------------------------------
// Chained hash table unit
// Key/value table with separate chaining behind two queue-style ports.
// ----------------------------------------------------------------------------
// Each item passes the front end's two mixer multiplies and then the back end's
// steps: take, head read, chain walk, action, result and pop; a set that adds an
// entry takes one more step, and a no-op skips the walk and the action. After
// reset a clearing pass over all buckets and entries runs before the first result.
// Front and back overlap: the front end takes a new item while the back end works.
`default_nettype none
module chained_hash_table_unit #(
  parameter int BUCKETS     = 64,
  parameter int ENTRIES     = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  command,
  input  wire logic [63:0] key,
  input  wire logic [31:0] value,
  output logic             empty,
  input  wire logic        pop,
  output logic             found,
  output logic [31:0]      value_out,
  output logic             status,
  output logic [6:0]       entry_total
);
  import cht_pkg::*;

  logic q_valid, q_take;
  req_t q_data;

  cht_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .key(key), .value(value), .q_valid(q_valid), .q_data(q_data), .q_take(q_take)
  );

  cht_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data), .q_take(q_take),
    .empty(empty), .pop(pop), .found(found), .value_out(value_out),
    .status(status), .entry_total(entry_total)
  );
endmodule
`default_nettype wire

@@ hw/rtl/cht_mul64.sv @@
// ----------------------------------------------------------------------------
// Chained hash table 64x32 multiplier
// Low 64 bits of x times the mixer constant, in two 32x32 partial products.
// ----------------------------------------------------------------------------
`default_nettype none
module cht_mul64 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] x,
  output logic             done,
  output logic [63:0]      prod
);
  import cht_pkg::*;

  logic [63:0] lo_part;
  logic [31:0] hi_x;
  logic [1:0]  phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        lo_part <= {32'd0, x[31:0]} * {32'd0, MIX_MUL};
        hi_x    <= x[63:32];
        phase   <= 2'd1;
      end else if (phase == 2'd1) begin
        prod  <= lo_part + {hi_x * MIX_MUL, 32'd0};
        phase <= 2'd0;
        done  <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/cht_front.sv @@
// ----------------------------------------------------------------------------
// Chained hash table front end
// Accepts requests, hashes the key and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module cht_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic [1:0]   command,
  input  wire logic [63:0]  key,
  input  wire logic [31:0]  value,
  output logic              q_valid,
  output cht_pkg::req_t     q_data,
  input  wire logic         q_take
);
  import cht_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL1 = 4'b0010,
    F_MUL2 = 4'b0100,
    F_OUT  = 4'b1000
  } fstate_t;

  fstate_t     state;
  req_t        cur;
  logic        m_start;
  logic        m_done;
  logic [63:0] m_x;
  logic [63:0] m_prod;
  req_t        q_mem [2];
  logic        wp, rp;
  logic [1:0]  count;

  cht_mul64 u_mul (
    .clk(clk), .rst(rst), .start(m_start), .x(m_x), .done(m_done), .prod(m_prod)
  );

  assign full    = (state != F_IDLE);
  assign q_valid = (count != 2'd0);
  assign q_data  = q_mem[rp];

  logic [63:0] vmask;
  assign vmask = ~64'd0 >> (64 - VALUE_WIDTH);

  always_comb begin
    m_start = 1'b0;
    m_x     = xsh(cur.hash);
    if (state == F_IDLE && push) begin
      m_start = 1'b1;
      m_x     = xsh(key + MIX_ADD);
    end else if (state == F_MUL1 && m_done) begin
      m_start = 1'b1;
      m_x     = xsh(m_prod);
    end
  end

  logic enq;
  assign enq = (state == F_OUT) && (count != 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      unique case (state)
        F_IDLE: if (push) begin
          cur.command <= cmd_t'(command);
          cur.key     <= key;
          cur.value   <= {32'd0, value} & vmask;
          state       <= F_MUL1;
        end
        F_MUL1: if (m_done) state <= F_MUL2;
        F_MUL2: if (m_done) begin
          cur.hash <= xsh(m_prod);
          state    <= F_OUT;
        end
        F_OUT: if (enq) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
      if (enq) begin
        q_mem[wp] <= cur;
        wp        <= ~wp;
      end
      if (q_take) rp <= ~rp;
      count <= count + {1'b0, enq} - {1'b0, q_take};
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/cht_back.sv @@
// ----------------------------------------------------------------------------
// Chained hash table back end
// Walks the bucket chain in memory and carries out set, get and delete.
// ----------------------------------------------------------------------------
`default_nettype none
`include "chained_hash_table_unit_macros.svh"
module cht_back #(
  parameter int BUCKETS     = 64,
  parameter int ENTRIES     = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  cht_pkg::req_t    q_data,
  output logic             q_take,
  output logic             empty,
  input  wire logic        pop,
  output logic             found,
  output logic [31:0]      value_out,
  output logic             status,
  output logic [6:0]       entry_total
);
  import cht_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int EW = $clog2(ENTRIES);
  localparam int LW = EW + 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

  typedef enum logic [7:0] {
    B_INIT  = 8'b00000001,
    B_IDLE  = 8'b00000010,
    B_HEAD  = 8'b00000100,
    B_RD    = 8'b00001000,
    B_CMP   = 8'b00010000,
    B_ACT   = 8'b00100000,
    B_FREE  = 8'b01000000,
    B_OUT   = 8'b10000000
  } bstate_t;

  logic [LW-1:0]          head_mem  [BUCKETS];
  logic [63:0]            key_mem   [ENTRIES];
  logic [VALUE_WIDTH-1:0] val_mem   [ENTRIES];
  logic [LW-1:0]          next_mem  [ENTRIES];
  logic [LW-1:0]          free_mem  [ENTRIES];

  bstate_t       state;
  req_t          req;
  logic [BW-1:0] bkt;
  logic [LW-1:0] cur, prev, head_val;
  logic [LW:0]   steps;
  logic [LW-1:0] count;
  logic [12:0]   init_idx;
  logic [63:0]            rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [LW-1:0]          rd_next, rd_free;
  logic          hit;

  logic [LW-1:0] free_top;
  assign free_top = LW'(ENTRIES - 1) - count;

  // first step of a walk reads the chain head directly
  logic [LW-1:0] rd_addr;
  assign rd_addr = (state == B_RD && steps == '0) ? head_val : cur;

  assign q_take = (state == B_IDLE) && q_valid;
  assign empty  = (state != B_OUT);

  always_ff @(posedge clk) begin
    head_val <= head_mem[bkt];
    if (rd_addr < NULL_LINK) begin
      rd_key  <= key_mem[rd_addr[EW-1:0]];
      rd_val  <= val_mem[rd_addr[EW-1:0]];
      rd_next <= next_mem[rd_addr[EW-1:0]];
    end
    rd_free <= free_mem[free_top[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_INIT;
      count    <= '0;
      init_idx <= '0;
    end else begin
      unique case (state)
        B_INIT: begin
          if (init_idx < 13'(BUCKETS)) head_mem[init_idx[BW-1:0]] <= NULL_LINK;
          if (init_idx < 13'(ENTRIES)) free_mem[init_idx[EW-1:0]] <= init_idx[LW-1:0];
          init_idx <= init_idx + 13'd1;
          if (init_idx >= 13'(BUCKETS) && init_idx >= 13'(ENTRIES)) state <= B_IDLE;
        end
        B_IDLE: if (q_valid) begin
          req    <= q_data;
          bkt    <= q_data.hash[BW-1:0];
          state  <= B_HEAD;
        end
        B_HEAD: begin
          cur    <= NULL_LINK;
          prev   <= NULL_LINK;
          steps  <= '0;
          hit    <= 1'b0;
          if (req.command == CMD_NOP) begin
            found <= 1'b0; value_out <= '0; status <= STATUS_OK;
            entry_total <= 7'(count);
            state <= B_OUT;
          end else begin
            state <= B_RD;
          end
        end
        B_RD: begin
          if (steps == '0) cur <= head_val;
          state <= B_CMP;
        end
        B_CMP: begin
          if (cur >= NULL_LINK || steps >= (LW+1)'(ENTRIES)) begin
            hit   <= 1'b0;
            state <= B_ACT;
          end else if (rd_key == req.key) begin
            hit   <= 1'b1;
            state <= B_ACT;
          end else begin
            prev   <= cur;
            cur    <= rd_next;
            steps  <= steps + 1'b1;
            state  <= B_RD;
          end
        end
        B_ACT: begin
          found <= hit;
          unique case (req.command)
            CMD_SET: begin
              value_out   <= '0;
              entry_total <= 7'(count);
              if (hit) begin
                val_mem[cur[EW-1:0]] <= req.value[VALUE_WIDTH-1:0];
                status <= STATUS_OK;
                state  <= B_OUT;
              end else if (count >= NULL_LINK) begin
                status <= STATUS_FULL;
                state  <= B_OUT;
              end else begin
                status <= STATUS_OK;
                state  <= B_FREE;
              end
            end
            CMD_GET: begin
              value_out   <= hit ? 32'(rd_val) : 32'd0;
              status      <= STATUS_OK;
              entry_total <= 7'(count);
              state       <= B_OUT;
            end
            CMD_DEL: begin
              value_out <= hit ? 32'(rd_val) : 32'd0;
              status    <= STATUS_OK;
              state     <= B_OUT;
              if (hit) begin
                if (prev < NULL_LINK) next_mem[prev[EW-1:0]] <= rd_next;
                else head_mem[bkt] <= rd_next;
                if (count != '0) begin
                  free_mem[EW'(free_top + 1'b1)] <= cur;
                  count       <= count - 1'b1;
                  entry_total <= 7'(count - 1'b1);
                end else begin
                  entry_total <= 7'(count);
                end
              end else begin
                entry_total <= 7'(count);
              end
            end
            default: begin
              value_out   <= '0;
              status      <= STATUS_OK;
              entry_total <= 7'(count);
              state       <= B_OUT;
            end
          endcase
        end
        B_FREE: begin
          automatic logic [EW-1:0] e = (rd_free < NULL_LINK) ? rd_free[EW-1:0] : '0;
          key_mem[e]  <= req.key;
          val_mem[e]  <= req.value[VALUE_WIDTH-1:0];
          next_mem[e] <= head_val;
          head_mem[bkt] <= {1'b0, e};
          count       <= count + 1'b1;
          entry_total <= 7'(count + 1'b1);
          state       <= B_OUT;
        end
        B_OUT: if (pop) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  `CHT_ASSERT_IMPL(a_count_range, 1'b1, count <= NULL_LINK)
  `CHT_ASSERT_IMPL(a_take_idle, q_take, state == B_IDLE)
  `CHT_ASSERT_NEXT(a_hold_out, (state == B_OUT) && !pop, state == B_OUT)
endmodule
`default_nettype wire

@@ tb/sv/chained_hash_table_unit_test.sv @@
// ----------------------------------------------------------------------------
// Chained hash table unit testbench
// Drives set, get, delete and no-op requests through the queue-style ports, predicts
// each result with a local chained table and checks every field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module chained_hash_table_unit_test;
  import cht_pkg::*;

  localparam int NB = 64;
  localparam int NE = 64;
  localparam int NULL_LINK = NE;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    cmd_t        command;
    logic [63:0] key;
    logic [31:0] value;
  } request_t;

  typedef struct packed {
    logic        found;
    logic [31:0] value_out;
    logic        status;
    logic [6:0]  entry_total;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [1:0] command = '0;
  logic [63:0] key = '0;
  logic [31:0] value = '0;
  logic full, empty, found, status;
  logic [31:0] value_out;
  logic [6:0] entry_total;

  chained_hash_table_unit DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .key(key), .value(value), .empty(empty), .pop(pop), .found(found),
    .value_out(value_out), .status(status), .entry_total(entry_total)
  );

  // predictor state
  int          head [NB];
  logic [63:0] ekey [NE];
  logic [31:0] eval [NE];
  int          enext [NE];
  int          pool [NE];
  int          count;

  request_t pending [$];
  answer_t  expected_answers [$];
  logic [63:0] known_keys [$];

  int send_idle = 27;
  int recv_idle = 85;
  bit hold_recv = 1'b0;
  int mismatches = 0;
  int checked = 0;
  int quiet = 0;
  int n_set = 0, n_get = 0, n_del = 0, n_nop = 0, n_full = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] mix(input logic [63:0] k);
    logic [63:0] h;
    h = k + 64'd4355467;
    h = (h ^ (h >> 16)) * 64'h045d9f3b;
    h = (h ^ (h >> 16)) * 64'h045d9f3b;
    return h ^ (h >> 16);
  endfunction

  function automatic answer_t predict(input request_t r);
    answer_t a;
    int b, cur, prev, hit, e, steps;
    a = '0;
    b = int'(mix(r.key) % NB);
    cur = head[b];
    prev = NULL_LINK;
    hit = NULL_LINK;
    for (steps = 0; steps < NE && cur < NE; steps++) begin
      if (ekey[cur] == r.key) begin
        hit = cur;
        break;
      end
      prev = cur;
      cur = enext[cur];
    end
    if (hit == NULL_LINK) prev = NULL_LINK;
    if (r.command != CMD_NOP) a.found = (hit < NE);
    case (r.command)
      CMD_SET: begin
        if (hit < NE) eval[hit] = r.value;
        else if (count >= NE) a.status = STATUS_FULL;
        else begin
          e = pool[NE - 1 - count];
          ekey[e] = r.key;
          eval[e] = r.value;
          enext[e] = head[b];
          head[b] = e;
          count++;
        end
      end
      CMD_GET: if (hit < NE) a.value_out = eval[hit];
      CMD_DEL: if (hit < NE) begin
        a.value_out = eval[hit];
        if (prev < NE) enext[prev] = enext[hit];
        else head[b] = enext[hit];
        pool[NE - count] = hit;
        count--;
      end
      default: ;
    endcase
    a.entry_total = count[6:0];
    return a;
  endfunction

  function automatic logic [63:0] pick_key();
    if (known_keys.size() > 0 && $urandom_range(0, 3) != 0)
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic add(input cmd_t c, input logic [63:0] k, input logic [31:0] v);
    request_t r;
    r.command = c;
    r.key = k;
    r.value = v;
    pending.push_back(r);
    if (c == CMD_SET && known_keys.size() < 200) known_keys.push_back(k);
  endtask

  task automatic random_batch(input int n, input int set_weight);
    int w;
    cmd_t c;
    for (int i = 0; i < n; i++) begin
      w = $urandom_range(0, 99);
      if (w < set_weight) c = CMD_SET;
      else if (w < set_weight + (100 - set_weight) / 2) c = CMD_GET;
      else if (w < 98) c = CMD_DEL;
      else c = CMD_NOP;
      add(c, pick_key(), $urandom);
    end
  endtask

  task automatic wait_drained();
    while (pending.size() > 0 || expected_answers.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_answers.push_back(predict('{cmd_t'(command), key, value}));
        case (cmd_t'(command))
          CMD_SET: n_set++;
          CMD_GET: n_get++;
          CMD_DEL: n_del++;
          default: n_nop++;
        endcase
        void'(pending.pop_front());
      end
      if (!(push && full)) begin
        if (pending.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          request_t r;
          r = pending[0];
          push <= 1'b1;
          command <= r.command;
          key <= r.key;
          value <= r.value;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        answer_t exp_a;
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item: found %0d value %h", found, value_out);
        end else begin
          exp_a = expected_answers.pop_front();
          checked++;
          if (exp_a.status) n_full++;
          if (exp_a != {found, value_out, status, entry_total}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp found %0d val %h st %0d tot %0d, got %0d %h %0d %0d",
                exp_a.found, exp_a.value_out, exp_a.status, exp_a.entry_total,
                found, value_out, status, entry_total);
          end
        end
      end
      pop <= !hold_recv && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NB; i++) head[i] = NULL_LINK;
    for (int i = 0; i < NE; i++) begin
      ekey[i] = '0;
      eval[i] = '0;
      enext[i] = NULL_LINK;
      pool[i] = i;
    end
    count = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every command, miss, overwrite, no-op
    add(CMD_GET, 64'h0, 32'h0);
    add(CMD_DEL, 64'h0, 32'h0);
    add(CMD_SET, 64'h0, 32'hffffffff);
    add(CMD_SET, 64'hffffffffffffffff, 32'h0);
    add(CMD_GET, 64'h0, 32'h0);
    add(CMD_GET, 64'hffffffffffffffff, 32'hffffffff);
    add(CMD_SET, 64'h0, 32'h5a5a5a5a);
    add(CMD_GET, 64'h0, 32'h0);
    add(CMD_NOP, 64'h0, 32'hffffffff);
    add(CMD_DEL, 64'hffffffffffffffff, 32'h0);
    add(CMD_GET, 64'hffffffffffffffff, 32'h0);
    add(CMD_DEL, 64'h0, 32'h0);
    add(CMD_DEL, 64'h0, 32'h0);
    add(CMD_NOP, 64'hffffffffffffffff, 32'h0);
    wait_drained();

    // fill past capacity to reach the full case, then empty again
    for (int i = 0; i < 70; i++) add(CMD_SET, {$urandom, $urandom}, $urandom);
    random_batch(60, 20);
    for (int i = 0; i < known_keys.size(); i++) add(CMD_DEL, known_keys[i], 32'h0);
    known_keys.delete();
    random_batch(500, 45);
    wait_drained();

    // long receiver hold-off while items keep coming
    send_idle = 0;
    hold_recv = 1'b1;
    random_batch(40, 50);
    repeat (300) @(posedge clk);
    hold_recv = 1'b0;
    wait_drained();

    send_idle = 85;
    recv_idle = 27;
    random_batch(600, 40);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    random_batch(550, 55);
    wait_drained();

    $display("checked %0d items: %0d set, %0d get, %0d delete, %0d no-op, %0d full drops",
      checked, n_set, n_get, n_del, n_nop, n_full);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d items outstanding", mismatches, expected_answers.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
